/* hw/rtl/julian_day_to_date_defines.svh */
// ----------------------------------------------------------------------------
// julian_day_to_date assertion macros
// shared property forms for the port checker, clocked on clk, off in reset
// ----------------------------------------------------------------------------
`ifndef JULIAN_DAY_TO_DATE_DEFINES_SVH
`define JULIAN_DAY_TO_DATE_DEFINES_SVH

// same-cycle implication
`define JDD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define JDD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hw/rtl/jdd_pkg.sv */
// ----------------------------------------------------------------------------
// jdd_pkg
// constants, reciprocals and stage payload types for the day-to-date pipeline
// ----------------------------------------------------------------------------
package jdd_pkg;

  localparam int JDD_DN_W    = 23;
  localparam int JDD_Z_W     = 24;
  localparam int JDD_B_W     = 24;
  localparam int JDD_C_W     = 15;
  localparam int JDD_X_W     = 10;
  localparam int JDD_E_W     = 6;
  localparam int JDD_YEAR_W  = 16;
  localparam int JDD_MONTH_W = 4;
  localparam int JDD_DOM_W   = 5;

  localparam logic [23:0] JDD_GREG_START = 24'd2299161;
  localparam logic [23:0] JDD_YEAR_ONE   = 24'd1721423;
  localparam logic [25:0] JDD_ALPHA_OFS  = 26'd7468865;
  localparam logic [23:0] JDD_B_OFS_AD   = 24'd1524;
  localparam logic [23:0] JDD_B_OFS_BC   = 24'd1158;
  localparam logic [27:0] JDD_C_OFS      = 28'd2442;
  localparam logic [15:0] JDD_YR_OFS_LATE  = 16'd4716;
  localparam logic [15:0] JDD_YR_OFS_EARLY = 16'd4715;

  // exact floor division by reciprocal: m = ceil(2^s / d), s = n_bits + ceil(log2 d)
  localparam int JDD_S1 = 43;  // /146097, 25-bit numerator
  localparam int JDD_S2 = 41;  // /7305, 28-bit numerator
  localparam int JDD_S3 = 43;  // /306001, 24-bit numerator
  localparam int JDD_S4 = 39;  // /10000, 25-bit numerator

  localparam longint unsigned JDD_M1_L =
    ((64'd1 << JDD_S1) + 64'd146096) / 64'd146097;
  localparam longint unsigned JDD_M2_L =
    ((64'd1 << JDD_S2) + 64'd7304) / 64'd7305;
  localparam longint unsigned JDD_M3_L =
    ((64'd1 << JDD_S3) + 64'd306000) / 64'd306001;
  localparam longint unsigned JDD_M4_L =
    ((64'd1 << JDD_S4) + 64'd9999) / 64'd10000;

  localparam logic [25:0] JDD_M1 = 26'(JDD_M1_L);
  localparam logic [28:0] JDD_M2 = 29'(JDD_M2_L);
  // scale factors folded into the reciprocal
  localparam logic [38:0] JDD_K3 = 39'(64'd10000 * JDD_M3_L);
  localparam logic [43:0] JDD_K4 = 44'(64'd306001 * JDD_M4_L);

  typedef struct packed {
    logic [JDD_B_W-1:0] b;
  } jdd_s2_t;

  typedef struct packed {
    logic [JDD_C_W-1:0] c;
    logic [JDD_X_W-1:0] x;
  } jdd_s4_t;

endpackage

/* hw/rtl/jdd_greg.sv */
// ----------------------------------------------------------------------------
// jdd_greg
// two stages: gregorian century correction, then offset into the year count
// ----------------------------------------------------------------------------
module jdd_greg (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        up_valid,
  output logic                        up_ready,
  input  logic [jdd_pkg::JDD_DN_W-1:0] up_day_number,
  output logic                        dn_valid,
  input  logic                        dn_ready,
  output jdd_pkg::jdd_s2_t            dn_data
);
  import jdd_pkg::*;

  logic                va_r, vb_r;
  logic                rdy_a, rdy_b;
  logic [JDD_Z_W-1:0]  z_nxt, z_r;
  logic                greg_nxt, greg_r;
  logic [25:0]         n1_wide;
  logic [24:0]         n1;
  logic [50:0]         p1_nxt, p1_r;
  logic [7:0]          alpha;
  logic [JDD_Z_W-1:0]  a;
  logic [JDD_B_W-1:0]  b_nxt, b_r;

  assign rdy_b    = !vb_r || dn_ready;
  assign rdy_a    = !va_r || rdy_b;
  assign up_ready = rdy_a;
  assign dn_valid = vb_r;
  assign dn_data.b = b_r;

  always_comb begin
    z_nxt    = {1'b0, up_day_number} + 24'd1;
    greg_nxt = z_nxt >= JDD_GREG_START;
    n1_wide  = (26'(z_nxt) << 2) - JDD_ALPHA_OFS;
    n1       = greg_nxt ? n1_wide[24:0] : 25'd0;
    p1_nxt   = 51'(n1) * 51'(JDD_M1);
  end

  always_comb begin
    alpha = p1_r[JDD_S1 +: 8];
    a     = greg_r ? z_r + 24'd1 + 24'(alpha) - 24'(alpha[7:2]) : z_r;
    b_nxt = a + ((a > JDD_YEAR_ONE) ? JDD_B_OFS_AD : JDD_B_OFS_BC);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
    end else begin
      if (rdy_a) va_r <= up_valid;
      if (rdy_b) vb_r <= va_r;
    end
  end

  always_ff @(posedge clk) begin
    if (up_valid && rdy_a) begin
      z_r    <= z_nxt;
      greg_r <= greg_nxt;
      p1_r   <= p1_nxt;
    end
    if (va_r && rdy_b) begin
      b_r <= b_nxt;
    end
  end

endmodule

/* hw/rtl/jdd_year.sv */
// ----------------------------------------------------------------------------
// jdd_year
// two stages: year count c by reciprocal, then day offset within that year
// ----------------------------------------------------------------------------
module jdd_year (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             up_valid,
  output logic             up_ready,
  input  jdd_pkg::jdd_s2_t up_data,
  output logic             dn_valid,
  input  logic             dn_ready,
  output jdd_pkg::jdd_s4_t dn_data
);
  import jdd_pkg::*;

  logic               va_r, vb_r;
  logic               rdy_a, rdy_b;
  logic [JDD_B_W-1:0] b_r;
  logic [27:0]        n2;
  logic [56:0]        p2_nxt, p2_r;
  logic [JDD_C_W-1:0] c_nxt, c_r;
  logic [25:0]        d_wide;
  logic [JDD_X_W-1:0] x_nxt, x_r;

  assign rdy_b    = !vb_r || dn_ready;
  assign rdy_a    = !va_r || rdy_b;
  assign up_ready = rdy_a;
  assign dn_valid = vb_r;
  assign dn_data.c = c_r;
  assign dn_data.x = x_r;

  always_comb begin
    // 20b - 2442
    n2     = (28'(up_data.b) << 4) + (28'(up_data.b) << 2) - JDD_C_OFS;
    p2_nxt = 57'(n2) * 57'(JDD_M2);
  end

  always_comb begin
    c_nxt  = p2_r[JDD_S2 +: JDD_C_W];
    d_wide = 26'(c_nxt) * 26'd1461;
    x_nxt  = JDD_X_W'(b_r - d_wide[25:2]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
    end else begin
      if (rdy_a) va_r <= up_valid;
      if (rdy_b) vb_r <= va_r;
    end
  end

  always_ff @(posedge clk) begin
    if (up_valid && rdy_a) begin
      b_r  <= up_data.b;
      p2_r <= p2_nxt;
    end
    if (va_r && rdy_b) begin
      c_r <= c_nxt;
      x_r <= x_nxt;
    end
  end

endmodule

/* hw/rtl/jdd_month.sv */
// ----------------------------------------------------------------------------
// jdd_month
// two stages: month index e by reciprocal, then day, month and year out
// ----------------------------------------------------------------------------
module jdd_month (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              up_valid,
  output logic                              up_ready,
  input  jdd_pkg::jdd_s4_t                  up_data,
  output logic                              dn_valid,
  input  logic                              dn_ready,
  output logic signed [jdd_pkg::JDD_YEAR_W-1:0] dn_year,
  output logic [jdd_pkg::JDD_MONTH_W-1:0]   dn_month,
  output logic [jdd_pkg::JDD_DOM_W-1:0]     dn_day_of_month
);
  import jdd_pkg::*;

  logic                  va_r, vb_r;
  logic                  rdy_a, rdy_b;
  logic [48:0]           p3_nxt, p3_r;
  logic [JDD_C_W-1:0]    c_r;
  logic [JDD_X_W-1:0]    x_r;
  logic [JDD_E_W-1:0]    e;
  logic [49:0]           p4;
  logic [10:0]           t;
  logic [JDD_E_W-1:0]    mon_full;
  logic                  late;
  logic [JDD_YEAR_W-1:0] yr_nxt;
  logic [JDD_MONTH_W-1:0] mon_nxt;
  logic [JDD_DOM_W-1:0]  dom_nxt;
  logic [JDD_YEAR_W-1:0] yr_r;
  logic [JDD_MONTH_W-1:0] mon_r;
  logic [JDD_DOM_W-1:0]  dom_r;

  assign rdy_b           = !vb_r || dn_ready;
  assign rdy_a           = !va_r || rdy_b;
  assign up_ready        = rdy_a;
  assign dn_valid        = vb_r;
  assign dn_year         = $signed(yr_r);
  assign dn_month        = mon_r;
  assign dn_day_of_month = dom_r;

  assign p3_nxt = 49'(up_data.x) * 49'(JDD_K3);

  always_comb begin
    e        = p3_r[JDD_S3 +: JDD_E_W];
    // floor(30.6001 e)
    p4       = 50'(e) * 50'(JDD_K4);
    t        = p4[JDD_S4 +: 11];
    dom_nxt  = JDD_DOM_W'({1'b0, x_r} - t);
    mon_full = e - ((e <= 6'd13) ? 6'd1 : 6'd13);
    mon_nxt  = JDD_MONTH_W'(mon_full);
    late     = mon_full > 6'd2;
    yr_nxt   = 16'(c_r) - (late ? JDD_YR_OFS_LATE : JDD_YR_OFS_EARLY);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
    end else begin
      if (rdy_a) va_r <= up_valid;
      if (rdy_b) vb_r <= va_r;
    end
  end

  always_ff @(posedge clk) begin
    if (up_valid && rdy_a) begin
      c_r  <= up_data.c;
      x_r  <= up_data.x;
      p3_r <= p3_nxt;
    end
    if (va_r && rdy_b) begin
      yr_r  <= yr_nxt;
      mon_r <= mon_nxt;
      dom_r <= dom_nxt;
    end
  end

endmodule

/* hw/rtl/julian_day_to_date.sv */
// ----------------------------------------------------------------------------
// julian_day_to_date
// day count to calendar date, julian rules before the gregorian switch
// ----------------------------------------------------------------------------
//  channel | ports                                          | dir
//  --------+------------------------------------------------+-----
//  in      | in_valid, in_ready, in_day_number[22:0]        | in
//  out     | out_valid, out_ready, out_year[15:0] (signed), | out
//          | out_month[3:0], out_day_of_month[4:0]          |
//
// six register stages, one beat in per cycle while in_ready is high; the
// stage count is set by the four reciprocal multiplies
// synchronous active-low reset clears only the stage valid bits
// a stall on out holds every full stage; in_ready drops only while out is
// stalled and the pipeline is full behind it
// ----------------------------------------------------------------------------
module julian_day_to_date (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic [jdd_pkg::JDD_DN_W-1:0]          in_day_number,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic signed [jdd_pkg::JDD_YEAR_W-1:0] out_year,
  output logic [jdd_pkg::JDD_MONTH_W-1:0]       out_month,
  output logic [jdd_pkg::JDD_DOM_W-1:0]         out_day_of_month
);
  import jdd_pkg::*;

  logic    s2_valid, s2_ready;
  jdd_s2_t s2_data;
  logic    s4_valid, s4_ready;
  jdd_s4_t s4_data;

  jdd_greg u_greg (
    .clk           (clk),
    .rst_n         (rst_n),
    .up_valid      (in_valid),
    .up_ready      (in_ready),
    .up_day_number (in_day_number),
    .dn_valid      (s2_valid),
    .dn_ready      (s2_ready),
    .dn_data       (s2_data)
  );

  jdd_year u_year (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (s2_valid),
    .up_ready (s2_ready),
    .up_data  (s2_data),
    .dn_valid (s4_valid),
    .dn_ready (s4_ready),
    .dn_data  (s4_data)
  );

  jdd_month u_month (
    .clk             (clk),
    .rst_n           (rst_n),
    .up_valid        (s4_valid),
    .up_ready        (s4_ready),
    .up_data         (s4_data),
    .dn_valid        (out_valid),
    .dn_ready        (out_ready),
    .dn_year         (out_year),
    .dn_month        (out_month),
    .dn_day_of_month (out_day_of_month)
  );

endmodule

/* hw/rtl/julian_day_to_date_checker.sv */
// ----------------------------------------------------------------------------
// julian_day_to_date_checker
// port-level checks on backpressure and result ranges, bound to the top level
// ----------------------------------------------------------------------------
`include "julian_day_to_date_defines.svh"

module julian_day_to_date_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [15:0] out_year,
  input logic [3:0]  out_month,
  input logic [4:0]  out_day_of_month
);

  // a stalled result beat holds its payload
  `JDD_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_year) && $stable(out_month) && $stable(out_day_of_month), "stalled result beat changed")

  // the pipeline pushes back only when the result side is stalled
  `JDD_ASSERT_NOW(a_ready_bp, !in_ready, out_valid && !out_ready, "in_ready low without output stall")

  `JDD_ASSERT_NOW(a_month_rng, out_valid, out_month >= 4'd1 && out_month <= 4'd12, "month out of range")

  `JDD_ASSERT_NOW(a_day_rng, out_valid, out_day_of_month != 5'd0, "day of month is zero")

endmodule

bind julian_day_to_date julian_day_to_date_checker u_jdd_chk (.*);
